[hw/rtl/msc_pkg.sv]
// shared types and constants for the motor servo command framer
// no dependencies; imported by every module of the block
package msc_pkg;

  // payload of one input beat
  typedef struct packed {
    logic signed [7:0] speed_percent;
    logic [31:0]       servo_word;
  } msc_in_t;

  // payload of one result beat
  typedef struct packed {
    logic       link_select;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       last_byte;
  } msc_out_t;

  // one prepared item handed from the converter to the serializer
  typedef struct packed {
    logic            neg;
    logic [4:0][3:0] digits;    // index 0 is the ones digit
    logic [2:0]      ndig_m1;   // digit count minus one
    logic [31:0]     servo_word;
    logic [7:0]      csum;
  } msc_frame_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_V,
    ST_MINUS,
    ST_DIGIT,
    ST_CR,
    ST_SERVO
  } msc_state_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SERVO_ID   = 2'd0;
  localparam logic [1:0] REG_START_ADDR = 2'd1;
  localparam logic [1:0] REG_SPEED_SCALE = 2'd2;

  localparam logic [7:0] SERVO_ID_RST    = 8'd0;
  localparam logic [7:0] START_ADDR_RST  = 8'd30;
  localparam logic [8:0] SPEED_SCALE_RST = 9'd120;

  localparam logic [7:0] SPEED_LIMIT = 8'd100;

  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [7:0] SERVO_HDR   = 8'hff;
  localparam logic [7:0] SERVO_LEN   = 8'h07;
  localparam logic [7:0] SERVO_WRITE = 8'h03;

  // byte positions inside the servo packet
  localparam logic [3:0] SRV_HDR0 = 4'd0;
  localparam logic [3:0] SRV_HDR1 = 4'd1;
  localparam logic [3:0] SRV_ID   = 4'd2;
  localparam logic [3:0] SRV_LEN  = 4'd3;
  localparam logic [3:0] SRV_INS  = 4'd4;
  localparam logic [3:0] SRV_ADDR = 4'd5;
  localparam logic [3:0] SRV_W0   = 4'd6;
  localparam logic [3:0] SRV_W1   = 4'd7;
  localparam logic [3:0] SRV_W2   = 4'd8;
  localparam logic [3:0] SRV_W3   = 4'd9;
  localparam logic [3:0] SRV_CSUM = 4'd10;

  localparam int          DIG_COUNT = 5;
  localparam logic [2:0]  DIG_STEPS = 3'd5;
  // reciprocal of ten, exact for 16-bit values with a shift of 19
  localparam logic [15:0] RECIP_TEN = 16'd52429;

endpackage

[hw/rtl/msc_convert.sv]
// input register, clamp and scale, decimal digit unit and checksum
// depends on msc_pkg
module msc_convert import msc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  msc_in_t     in_data,
  input  logic [8:0]  speed_scale,
  input  logic [7:0]  servo_id,
  input  logic [7:0]  servo_start_address,
  output logic        frame_valid,
  input  logic        frame_ready,
  output msc_frame_t  frame
);

  logic            p_valid_r;
  logic [2:0]      cnt_r;
  logic [15:0]     val_r;
  logic            neg_r;
  logic [31:0]     word_r;
  logic [4:0][3:0] dig_r;

  logic        accept;
  logic        stepping;
  logic        neg_in;
  logic [7:0]  abs_in;
  logic [6:0]  mag_in;
  logic [15:0] prod_in;
  logic [31:0] recip_prod;
  logic [12:0] quot;
  logic [15:0] rem_full;
  logic [2:0]  ndig_m1;
  logic [7:0]  csum_sum;

  assign frame_valid = p_valid_r && (cnt_r == DIG_STEPS);
  assign in_ready    = !p_valid_r || (frame_valid && frame_ready);
  assign accept      = in_valid && in_ready;
  assign stepping    = p_valid_r && (cnt_r != DIG_STEPS);

  // clamp to the speed limit, then scale
  always_comb begin
    neg_in  = in_data.speed_percent[7];
    abs_in  = neg_in ? (~in_data.speed_percent + 8'd1) : in_data.speed_percent;
    mag_in  = (abs_in > SPEED_LIMIT) ? SPEED_LIMIT[6:0] : abs_in[6:0];
    prod_in = {9'd0, mag_in} * {7'd0, speed_scale};
  end

  // one decimal digit per cycle
  always_comb begin
    recip_prod = val_r * RECIP_TEN;
    quot       = recip_prod[31:19];
    rem_full   = val_r - ({3'd0, quot} * 16'd10);
  end

  always_comb begin
    priority if (dig_r[4] != 4'd0) ndig_m1 = 3'd4;
    else if (dig_r[3] != 4'd0)      ndig_m1 = 3'd3;
    else if (dig_r[2] != 4'd0)      ndig_m1 = 3'd2;
    else if (dig_r[1] != 4'd0)      ndig_m1 = 3'd1;
    else                            ndig_m1 = 3'd0;
  end

  assign csum_sum = servo_id + SERVO_LEN + SERVO_WRITE + servo_start_address
                  + word_r[7:0] + word_r[15:8] + word_r[23:16] + word_r[31:24];

  always_comb begin
    frame.neg        = neg_r;
    frame.digits     = dig_r;
    frame.ndig_m1    = ndig_m1;
    frame.servo_word = word_r;
    frame.csum       = ~csum_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      cnt_r     <= 3'd0;
    end else if (accept) begin
      p_valid_r <= 1'b1;
      cnt_r     <= 3'd0;
    end else if (frame_valid && frame_ready) begin
      p_valid_r <= 1'b0;
    end else if (stepping) begin
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_r  <= prod_in;
      neg_r  <= neg_in;
      word_r <= in_data.servo_word;
    end else if (stepping) begin
      val_r <= {3'd0, quot};
      dig_r <= {rem_full[3:0], dig_r[DIG_COUNT-1:1]};
    end
  end

endmodule

[hw/rtl/msc_serializer.sv]
// frame sequencer and output register, one byte per beat
// depends on msc_pkg
module msc_serializer import msc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       frame_valid,
  output logic       frame_ready,
  input  msc_frame_t frame,
  input  logic [7:0] servo_id,
  input  logic [7:0] servo_start_address,
  output logic       out_valid,
  input  logic       out_ready,
  output msc_out_t   out_data
);

  msc_state_t state_r, state_nxt;
  msc_frame_t frame_r;
  logic [2:0] dig_r, dig_nxt;
  logic [3:0] srv_r, srv_nxt;
  logic       out_valid_r;
  msc_out_t   out_r;

  logic       emit;
  logic       load;
  msc_out_t   beat;
  logic [3:0] cur_digit;

  assign emit     = (state_r != ST_IDLE) && (!out_valid_r || out_ready);
  assign cur_digit = frame_r.digits[dig_r];

  always_comb begin
    frame_ready = (state_r == ST_IDLE)
               || ((state_r == ST_SERVO) && (srv_r == SRV_CSUM) && emit);
  end
  assign load = frame_valid && frame_ready;

  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    srv_nxt   = srv_r;
    beat      = '0;
    unique case (state_r)
      ST_IDLE: begin
        state_nxt = ST_IDLE;
      end
      ST_V: begin
        beat.data_byte = CH_V;
        if (emit) state_nxt = frame_r.neg ? ST_MINUS : ST_DIGIT;
      end
      ST_MINUS: begin
        beat.data_byte = CH_MINUS;
        if (emit) state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        beat.data_byte = CH_ZERO + {4'd0, cur_digit};
        if (emit) begin
          if (dig_r == 3'd0) state_nxt = ST_CR;
          else               dig_nxt   = dig_r - 3'd1;
        end
      end
      ST_CR: begin
        beat.data_byte = CH_CR;
        beat.frame_end = 1'b1;
        if (emit) begin
          state_nxt = ST_SERVO;
          srv_nxt   = SRV_HDR0;
        end
      end
      ST_SERVO: begin
        beat.link_select = 1'b1;
        unique case (srv_r)
          SRV_HDR0, SRV_HDR1: beat.data_byte = SERVO_HDR;
          SRV_ID:   beat.data_byte = servo_id;
          SRV_LEN:  beat.data_byte = SERVO_LEN;
          SRV_INS:  beat.data_byte = SERVO_WRITE;
          SRV_ADDR: beat.data_byte = servo_start_address;
          SRV_W0:   beat.data_byte = frame_r.servo_word[7:0];
          SRV_W1:   beat.data_byte = frame_r.servo_word[15:8];
          SRV_W2:   beat.data_byte = frame_r.servo_word[23:16];
          SRV_W3:   beat.data_byte = frame_r.servo_word[31:24];
          SRV_CSUM: begin
            beat.data_byte = frame_r.csum;
            beat.frame_end = 1'b1;
            beat.last_byte = 1'b1;
          end
          default:  beat.data_byte = SERVO_HDR;
        endcase
        if (emit) begin
          if (srv_r == SRV_CSUM) state_nxt = ST_IDLE;
          else                   srv_nxt   = srv_r + 4'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // a waiting frame starts right behind the checksum
    if (load) begin
      state_nxt = ST_V;
      dig_nxt   = frame.ndig_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dig_r       <= 3'd0;
      srv_r       <= 4'd0;
    end else begin
      state_r <= state_nxt;
      dig_r   <= dig_nxt;
      srv_r   <= srv_nxt;
      if (emit)          out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) frame_r <= frame;
    if (emit) out_r   <= beat;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/motor_servo_command_framer.sv]
// motor servo command framer top; needs msc_pkg, msc_convert and msc_serializer
// each item gives a speed text frame followed by a servo write packet
// first byte (the 'v'): input register, digit steps, frame load, then output register
// throughput: one byte per cycle while out_ready is high; 14 to 19 bytes per item (3..8
//   speed, 11 servo); the next item converts while a frame streams, so no gaps
// reset: synchronous active-low rst_n empties the pipeline and loads register defaults
module motor_servo_command_framer import msc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  msc_in_t     in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output msc_out_t    out_data,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [7:0] servo_id_r;
  logic [7:0] start_addr_r;
  logic [8:0] speed_scale_r;

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // converter to serializer handoff
  logic       frame_valid;
  logic       frame_ready;
  msc_frame_t frame;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register writes, data truncated to register width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_id_r    <= SERVO_ID_RST;
      start_addr_r  <= START_ADDR_RST;
      speed_scale_r <= SPEED_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SERVO_ID:    servo_id_r    <= cfg_pwdata[7:0];
        REG_START_ADDR:  start_addr_r  <= cfg_pwdata[7:0];
        REG_SPEED_SCALE: speed_scale_r <= cfg_pwdata[8:0];
        default: ;  // unused slot, write dropped
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (cfg_idx)
      REG_SERVO_ID:    cfg_prdata = {24'd0, servo_id_r};
      REG_START_ADDR:  cfg_prdata = {24'd0, start_addr_r};
      REG_SPEED_SCALE: cfg_prdata = {23'd0, speed_scale_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // clamp, scale, five-step decimal conversion and checksum
  msc_convert u_convert (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data             (in_data),
    .speed_scale         (speed_scale_r),
    .servo_id            (servo_id_r),
    .servo_start_address (start_addr_r),
    .frame_valid         (frame_valid),
    .frame_ready         (frame_ready),
    .frame               (frame)
  );

  // walks the speed frame then the servo packet, one beat per cycle while out_ready is high,
  // through a registered output stage
  msc_serializer u_serializer (
    .clk                 (clk),
    .rst_n               (rst_n),
    .frame_valid         (frame_valid),
    .frame_ready         (frame_ready),
    .frame               (frame),
    .servo_id            (servo_id_r),
    .servo_start_address (start_addr_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data            (out_data)
  );

endmodule
